FILE: src/bgr_pkg.sv
// Shared constants, types and codes for the bilinear grid resampler.
`default_nettype none
package bgr_pkg;

	localparam int SRC_W_MAX = 512;
	localparam int SRC_H_MAX = 256;
	localparam int DST_MAX   = 4096;
	localparam int FRAC      = 16;

	localparam int SW_W      = 10;
	localparam int SH_W      = 9;
	localparam int TD_W      = 13;
	localparam int COORD_W   = 12;
	localparam int SMP_W     = 16;

	localparam int XW        = $clog2(SRC_W_MAX);
	localparam int YW        = $clog2(SRC_H_MAX);
	localparam int ADDR_W    = XW + YW;
	localparam int GRID_DEPTH = SRC_W_MAX * SRC_H_MAX;
	localparam int DEN_W     = $clog2(DST_MAX);
	localparam int NUM_W     = COORD_W + XW;
	localparam int QUO_W     = DEN_W + FRAC;
	localparam int DIV_STEP  = 4;
	localparam int DIV_CYC   = QUO_W / DIV_STEP;
	localparam int STEP_W    = $clog2(DIV_CYC);
	localparam int WF_W      = FRAC + 1;
	localparam int WGT_W     = 2 * WF_W;
	localparam int PROD_W    = SMP_W + WGT_W;
	localparam int NB_CNT_W  = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FETCH,
		ST_DONE
	} state_t;

	// Control from the sequencer to the weighting datapath.
	typedef struct packed {
		logic       clear;
		logic       issue;
		logic [1:0] nb;
	} mac_ctl_t;

endpackage
`default_nettype wire

FILE: src/bgr_ram.sv
// Generic synchronous RAM: one write port, one registered read port.
`default_nettype none
module bgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/bgr_div.sv
// Radix-16 restoring divider giving position index and fraction in one quotient.
`default_nettype none
module bgr_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bgr_pkg::NUM_W-1:0]    num,
	input  wire logic [bgr_pkg::DEN_W-1:0]    den,
	output logic                              done,
	output logic      [bgr_pkg::QUO_W-1:0]    quot
);

	logic                          busy_q;
	logic [bgr_pkg::STEP_W-1:0]    step_q;
	logic [bgr_pkg::DEN_W-1:0]     rem_q;
	logic [bgr_pkg::DEN_W-1:0]     den_q;
	logic [bgr_pkg::QUO_W-1:0]     sh_q;
	logic [bgr_pkg::DEN_W-1:0]     rem_nx;
	logic [bgr_pkg::QUO_W-1:0]     sh_nx;
	logic [bgr_pkg::DEN_W:0]       trial;

	// Dividend is num * 2^FRAC; its top bits start out as the remainder.
	always_comb begin
		rem_nx = rem_q;
		sh_nx  = sh_q;
		trial  = '0;
		for (int i = 0; i < bgr_pkg::DIV_STEP; i++) begin
			trial = {rem_nx, sh_nx[bgr_pkg::QUO_W-1]};
			if (trial >= {1'b0, den_q}) begin
				rem_nx = bgr_pkg::DEN_W'(trial - {1'b0, den_q});
				sh_nx  = {sh_nx[bgr_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[bgr_pkg::DEN_W-1:0];
				sh_nx  = {sh_nx[bgr_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (step_q == bgr_pkg::STEP_W'(bgr_pkg::DIV_CYC - 1));
	assign quot = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= bgr_pkg::DEN_W'(num >> bgr_pkg::DEN_W);
			sh_q  <= {num[bgr_pkg::DEN_W-1:0], {bgr_pkg::FRAC{1'b0}}};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			sh_q  <= sh_nx;
		end
	end

endmodule
`default_nettype wire

FILE: src/bgr_mac.sv
// Weighting datapath: neighbor weight, weighted sample, accumulate, scale down.
`default_nettype none
module bgr_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bgr_pkg::mac_ctl_t                 ctl,
	input  wire logic        [bgr_pkg::FRAC-1:0]   fx,
	input  wire logic        [bgr_pkg::FRAC-1:0]   fy,
	input  wire logic signed [bgr_pkg::SMP_W-1:0]  rd_data,
	output logic                                   empty,
	output logic signed      [bgr_pkg::SMP_W-1:0]  pix
);

	localparam logic [bgr_pkg::WF_W-1:0] ONE = bgr_pkg::WF_W'(1) << bgr_pkg::FRAC;
	localparam logic [bgr_pkg::PROD_W-1:0] BIAS =
		(bgr_pkg::PROD_W'(1) << (2 * bgr_pkg::FRAC)) - 1'b1;

	logic                                vld_s1;
	logic [bgr_pkg::WGT_W-1:0]           w_s1;
	logic                                vld_s2;
	logic signed [bgr_pkg::PROD_W-1:0]   prod_s2;
	logic signed [bgr_pkg::PROD_W-1:0]   acc_q;
	logic [bgr_pkg::WF_W-1:0]            xw;
	logic [bgr_pkg::WF_W-1:0]            yw;
	logic signed [bgr_pkg::SMP_W-1:0]    smp;
	logic [bgr_pkg::PROD_W-1:0]          biased;

	assign xw = ctl.nb[0] ? {1'b0, fx} : ONE - {1'b0, fx};
	assign yw = ctl.nb[1] ? {1'b0, fy} : ONE - {1'b0, fy};

	// Zero-weight neighbors may not exist in the grid; drop their data.
	assign smp = (w_s1 == '0) ? '0 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= xw * yw;
		prod_s2 <= bgr_pkg::PROD_W'($signed(smp) * $signed({1'b0, w_s1}));
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Truncate toward zero: bias negative sums before the shift.
	assign biased = acc_q[bgr_pkg::PROD_W-1] ? (acc_q + BIAS) : acc_q;
	assign pix    = biased[2 * bgr_pkg::FRAC +: bgr_pkg::SMP_W];
	assign empty  = !vld_s1 && !vld_s2;

endmodule
`default_nettype wire

FILE: src/bilinear_grid_resampler.sv
// Top level: config registers, sequencer, source grid memory and output register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | req_type, col, row, sample
//  out      | out_valid / out_ready| pixel_value, range_error
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// A sample write goes to the grid at the accepting edge. A query outside the
// target size goes from accept straight to loading the output register. A query
// inside it steps through accept, multiply, 7 radix-16 divider steps, 4 reads of
// the grid memory's single read port through the weighting pipeline, and loading
// of the output register. Reset loads the size registers with their defaults and
// clears control state; grid contents stay undefined until written. A stalled
// output holds only the final step; writes and new items wait in idle.
`default_nettype none
module bilinear_grid_resampler (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               req_type,
	input  wire logic        [bgr_pkg::COORD_W-1:0] col,
	input  wire logic        [bgr_pkg::COORD_W-1:0] row,
	input  wire logic signed [bgr_pkg::SMP_W-1:0]   sample,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [bgr_pkg::SMP_W-1:0]   pixel_value,
	output logic                                    range_error,
	input  wire logic                               cfg_we,
	input  wire logic        [bgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [bgr_pkg::CFG_DATA_W-1:0] cfg_data
);

	bgr_pkg::state_t state_q, state_nx;

	logic [bgr_pkg::SW_W-1:0]     src_w_q;
	logic [bgr_pkg::SH_W-1:0]     src_h_q;
	logic [bgr_pkg::TD_W-1:0]     dst_w_q;
	logic [bgr_pkg::TD_W-1:0]     dst_h_q;
	logic [bgr_pkg::SW_W-1:0]     sw_use;
	logic [bgr_pkg::SH_W-1:0]     sh_use;
	logic [bgr_pkg::TD_W-1:0]     tw_use;
	logic [bgr_pkg::TD_W-1:0]     th_use;
	logic [bgr_pkg::XW-1:0]       sw_m1;
	logic [bgr_pkg::YW-1:0]       sh_m1;
	logic [bgr_pkg::DEN_W-1:0]    tw_m1;
	logic [bgr_pkg::DEN_W-1:0]    th_m1;

	logic [bgr_pkg::COORD_W-1:0]  col_q;
	logic [bgr_pkg::COORD_W-1:0]  row_q;
	logic [bgr_pkg::NB_CNT_W-1:0] cnt_q;
	logic                         err_q;

	logic                         accept;
	logic                         wr_ok;
	logic                         q_oor;
	logic                         div_start;
	logic [bgr_pkg::NUM_W-1:0]    num_x;
	logic [bgr_pkg::NUM_W-1:0]    num_y;
	logic                         done_x;
	logic                         done_y;
	logic [bgr_pkg::QUO_W-1:0]    quot_x;
	logic [bgr_pkg::QUO_W-1:0]    quot_y;
	logic [bgr_pkg::XW-1:0]       px;
	logic [bgr_pkg::YW-1:0]       py;
	logic [bgr_pkg::FRAC-1:0]     fx;
	logic [bgr_pkg::FRAC-1:0]     fy;
	logic [bgr_pkg::XW-1:0]       x_rd;
	logic [bgr_pkg::YW-1:0]       y_rd;

	logic                         ram_we;
	logic                         ram_re;
	logic [bgr_pkg::ADDR_W-1:0]   ram_waddr;
	logic [bgr_pkg::ADDR_W-1:0]   ram_raddr;
	logic [bgr_pkg::SMP_W-1:0]    ram_rdata;

	bgr_pkg::mac_ctl_t            mac_ctl;
	logic                         mac_empty;
	logic signed [bgr_pkg::SMP_W-1:0] mac_pix;

	logic                         out_load;
	logic                         out_valid_q;
	logic signed [bgr_pkg::SMP_W-1:0] pixel_value_q;
	logic                         range_error_q;

	// Size clamps.
	always_comb begin
		if (src_w_q < bgr_pkg::SW_W'(2)) begin
			sw_use = bgr_pkg::SW_W'(2);
		end else if (src_w_q > bgr_pkg::SW_W'(bgr_pkg::SRC_W_MAX)) begin
			sw_use = bgr_pkg::SW_W'(bgr_pkg::SRC_W_MAX);
		end else begin
			sw_use = src_w_q;
		end
		if (src_h_q < bgr_pkg::SH_W'(2)) begin
			sh_use = bgr_pkg::SH_W'(2);
		end else if (src_h_q > bgr_pkg::SH_W'(bgr_pkg::SRC_H_MAX)) begin
			sh_use = bgr_pkg::SH_W'(bgr_pkg::SRC_H_MAX);
		end else begin
			sh_use = src_h_q;
		end
		if (dst_w_q < bgr_pkg::TD_W'(2)) begin
			tw_use = bgr_pkg::TD_W'(2);
		end else if (dst_w_q > bgr_pkg::TD_W'(bgr_pkg::DST_MAX)) begin
			tw_use = bgr_pkg::TD_W'(bgr_pkg::DST_MAX);
		end else begin
			tw_use = dst_w_q;
		end
		if (dst_h_q < bgr_pkg::TD_W'(2)) begin
			th_use = bgr_pkg::TD_W'(2);
		end else if (dst_h_q > bgr_pkg::TD_W'(bgr_pkg::DST_MAX)) begin
			th_use = bgr_pkg::TD_W'(bgr_pkg::DST_MAX);
		end else begin
			th_use = dst_h_q;
		end
	end

	assign sw_m1 = bgr_pkg::XW'(sw_use - 1'b1);
	assign sh_m1 = bgr_pkg::YW'(sh_use - 1'b1);
	assign tw_m1 = bgr_pkg::DEN_W'(tw_use - 1'b1);
	assign th_m1 = bgr_pkg::DEN_W'(th_use - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= bgr_pkg::SW_W'(bgr_pkg::SRC_W_MAX);
			src_h_q <= bgr_pkg::SH_W'(bgr_pkg::SRC_H_MAX);
			dst_w_q <= bgr_pkg::TD_W'(512);
			dst_h_q <= bgr_pkg::TD_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				bgr_pkg::CFG_SRC_WIDTH:  src_w_q <= cfg_data[bgr_pkg::SW_W-1:0];
				bgr_pkg::CFG_SRC_HEIGHT: src_h_q <= cfg_data[bgr_pkg::SH_W-1:0];
				bgr_pkg::CFG_DST_WIDTH:  dst_w_q <= cfg_data[bgr_pkg::TD_W-1:0];
				bgr_pkg::CFG_DST_HEIGHT: dst_h_q <= cfg_data[bgr_pkg::TD_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;
	assign wr_ok  = ({1'b0, col} < 13'(sw_use)) && ({1'b0, row} < 13'(sh_use));
	assign q_oor  = ({1'b0, col} >= tw_use) || ({1'b0, row} >= th_use);

	// In-range sample writes go straight to the grid at the accepting edge.
	assign ram_we    = accept && (req_type == bgr_pkg::REQ_WRITE) && wr_ok;
	assign ram_waddr = {row[bgr_pkg::YW-1:0], col[bgr_pkg::XW-1:0]};

	assign num_x = bgr_pkg::NUM_W'(col_q) * bgr_pkg::NUM_W'(sw_m1);
	assign num_y = bgr_pkg::NUM_W'(row_q) * bgr_pkg::NUM_W'(sh_m1);

	bgr_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (tw_m1),
		.done   (done_x),
		.quot   (quot_x)
	);

	bgr_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (th_m1),
		.done   (done_y),
		.quot   (quot_y)
	);

	assign px = quot_x[bgr_pkg::FRAC +: bgr_pkg::XW];
	assign py = quot_y[bgr_pkg::FRAC +: bgr_pkg::YW];
	assign fx = quot_x[bgr_pkg::FRAC-1:0];
	assign fy = quot_y[bgr_pkg::FRAC-1:0];

	// Step to the next neighbor only when its weight is nonzero.
	assign x_rd = px + bgr_pkg::XW'(cnt_q[0] && (fx != '0));
	assign y_rd = py + bgr_pkg::YW'(cnt_q[1] && (fy != '0));
	assign ram_raddr = {y_rd, x_rd};

	bgr_ram #(
		.WIDTH (bgr_pkg::SMP_W),
		.DEPTH (bgr_pkg::GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sample),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bgr_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.fx      (fx),
		.fy      (fy),
		.rd_data ($signed(ram_rdata)),
		.empty   (mac_empty),
		.pix     (mac_pix)
	);

	always_comb begin
		state_nx      = state_q;
		in_ready      = 1'b0;
		div_start     = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		mac_ctl.clear = 1'b0;
		mac_ctl.issue = 1'b0;
		mac_ctl.nb    = cnt_q[1:0];
		case (state_q)
			bgr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (req_type == bgr_pkg::REQ_QUERY)) begin
					state_nx = q_oor ? bgr_pkg::ST_DONE : bgr_pkg::ST_MUL;
				end
			end
			bgr_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_nx  = bgr_pkg::ST_DIV;
			end
			bgr_pkg::ST_DIV: begin
				if (done_x) begin
					mac_ctl.clear = 1'b1;
					state_nx      = bgr_pkg::ST_FETCH;
				end
			end
			bgr_pkg::ST_FETCH: begin
				if (!cnt_q[bgr_pkg::NB_CNT_W-1]) begin
					ram_re        = 1'b1;
					mac_ctl.issue = 1'b1;
				end else if (mac_empty) begin
					state_nx = bgr_pkg::ST_DONE;
				end
			end
			bgr_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_nx = bgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bgr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (accept) begin
				err_q <= q_oor;
			end
			if (mac_ctl.clear) begin
				cnt_q <= '0;
			end else if (mac_ctl.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= col;
			row_q <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_value_q <= err_q ? '0 : mac_pix;
			range_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_value_q;
	assign range_error = range_error_q;

`ifndef SYNTHESIS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_x == done_y)
		else $error("axis dividers out of step");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		done_x |-> state_q == bgr_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_read_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (state_q == bgr_pkg::ST_FETCH) && !ram_we)
		else $error("grid read outside the fetch state");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && (!range_error || (pixel_value == '0)))
		else $error("range error result with nonzero pixel");
`endif

endmodule
`default_nettype wire

FILE: dv/bilinear_grid_resampler_tb.sv
// Self-checking testbench for the bilinear grid resampler: grid writes and pixel queries.
`default_nettype none
module bilinear_grid_resampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic signed [bgr_pkg::SMP_W-1:0] value;
		logic                             err;
	} pixel_t;

	class resample_scoreboard;
		logic signed [bgr_pkg::SMP_W-1:0] grid [bgr_pkg::GRID_DEPTH];
		bit                               filled [bgr_pkg::GRID_DEPTH];
		logic [bgr_pkg::SW_W-1:0]         src_w_reg;
		logic [bgr_pkg::SH_W-1:0]         src_h_reg;
		logic [bgr_pkg::TD_W-1:0]         dst_w_reg;
		logic [bgr_pkg::TD_W-1:0]         dst_h_reg;
		pixel_t                           expected_pixels [$];
		int                               errors;

		function new();
			src_w_reg = 10'd512;
			src_h_reg = 9'd256;
			dst_w_reg = 13'd512;
			dst_h_reg = 13'd256;
			errors = 0;
		endfunction

		function int unsigned bound(int unsigned v, int unsigned hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned src_w();
			return bound(src_w_reg, bgr_pkg::SRC_W_MAX);
		endfunction
		function int unsigned src_h();
			return bound(src_h_reg, bgr_pkg::SRC_H_MAX);
		endfunction
		function int unsigned dst_w();
			return bound(dst_w_reg, bgr_pkg::DST_MAX);
		endfunction
		function int unsigned dst_h();
			return bound(dst_h_reg, bgr_pkg::DST_MAX);
		endfunction

		function void set_register(logic [bgr_pkg::CFG_IDX_W-1:0] idx,
				logic [bgr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bgr_pkg::CFG_SRC_WIDTH:  src_w_reg = data[bgr_pkg::SW_W-1:0];
				bgr_pkg::CFG_SRC_HEIGHT: src_h_reg = data[bgr_pkg::SH_W-1:0];
				bgr_pkg::CFG_DST_WIDTH:  dst_w_reg = data[bgr_pkg::TD_W-1:0];
				bgr_pkg::CFG_DST_HEIGHT: dst_h_reg = data[bgr_pkg::TD_W-1:0];
				default: ;
			endcase
		endfunction

		// Integer index and 16-bit fraction of c*(s-1)/(t-1).
		function void locate(input int unsigned c, s, t,
				output int unsigned idx, output longint unsigned frac);
			longint unsigned num;
			longint unsigned den;
			num = longint'(c) * longint'(s - 1);
			den = t - 1;
			idx = int'(num / den);
			frac = ((num % den) << bgr_pkg::FRAC) / den;
		endfunction

		function void corners(input int unsigned c, r,
				output int unsigned x0, x1, y0, y1,
				output longint unsigned fx, fy);
			locate(c, src_w(), dst_w(), x0, fx);
			locate(r, src_h(), dst_h(), y0, fy);
			// zero fraction: the next neighbor is never read
			x1 = (fx != 0) ? x0 + 1 : x0;
			y1 = (fy != 0) ? y0 + 1 : y0;
		endfunction

		function longint tap(int unsigned x, int unsigned y, longint unsigned wgt);
			return longint'(grid[y * bgr_pkg::SRC_W_MAX + x]) * longint'(wgt);
		endfunction

		function pixel_t predict_pixel(int unsigned c, int unsigned r);
			pixel_t           px;
			int unsigned      x0, x1, y0, y1;
			longint unsigned  fx, fy;
			longint unsigned  one;
			longint           acc;
			longint           mag;
			one = longint'(1) << bgr_pkg::FRAC;
			px.value = '0;
			px.err = 1'b1;
			if (c >= dst_w() || r >= dst_h()) return px;
			corners(c, r, x0, x1, y0, y1, fx, fy);
			acc = tap(x0, y0, (one - fx) * (one - fy)) + tap(x1, y0, fx * (one - fy))
				+ tap(x0, y1, (one - fx) * fy) + tap(x1, y1, fx * fy);
			// truncate toward zero
			mag = (acc < 0) ? -acc : acc;
			mag = mag >> (2 * bgr_pkg::FRAC);
			if (acc < 0) mag = -mag;
			px.value = mag[bgr_pkg::SMP_W-1:0];
			px.err = 1'b0;
			return px;
		endfunction

		// Returns 1 when the item changes state or causes a result.
		function bit note_item(logic req, logic [bgr_pkg::COORD_W-1:0] c,
				logic [bgr_pkg::COORD_W-1:0] r, logic signed [bgr_pkg::SMP_W-1:0] smp);
			if (req == bgr_pkg::REQ_WRITE) begin
				if (c >= src_w() || r >= src_h()) return 1'b0;
				grid[r * bgr_pkg::SRC_W_MAX + c] = smp;
				filled[r * bgr_pkg::SRC_W_MAX + c] = 1'b1;
				return 1'b1;
			end
			expected_pixels.push_back(predict_pixel(c, r));
			return 1'b1;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pixel(logic signed [bgr_pkg::SMP_W-1:0] value, logic err);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result with nothing pending: value=%0d err=%0b", value, err));
				return;
			end
			want = expected_pixels.pop_front();
			if (value !== want.value)
				report($sformatf("pixel_value %0d, want %0d", value, want.value));
			if (err !== want.err)
				report($sformatf("range_error %0b, want %0b", err, want.err));
		endtask
	endclass

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_ready;
	logic                                   req_type = bgr_pkg::REQ_WRITE;
	logic        [bgr_pkg::COORD_W-1:0]     col = '0;
	logic        [bgr_pkg::COORD_W-1:0]     row = '0;
	logic signed [bgr_pkg::SMP_W-1:0]       sample = '0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic signed [bgr_pkg::SMP_W-1:0]       pixel_value;
	logic                                   range_error;
	logic                                   cfg_we = 1'b0;
	logic        [bgr_pkg::CFG_IDX_W-1:0]   cfg_index = bgr_pkg::CFG_SRC_WIDTH;
	logic        [bgr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	resample_scoreboard sb = new();
	int  cycles = 0;
	int  taken = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;

	bilinear_grid_resampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.col(col),
		.row(row),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_value(pixel_value),
		.range_error(range_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_pixel(pixel_value, range_error);
	end

	// Receiver stalls in bursts, none once the run turns quiet.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
		end
	end

	function automatic logic signed [bgr_pkg::SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			default: return bgr_pkg::SMP_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic req, input int unsigned c,
			input int unsigned r, input logic signed [bgr_pkg::SMP_W-1:0] s);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		col <= bgr_pkg::COORD_W'(c);
		row <= bgr_pkg::COORD_W'(r);
		sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (sb.note_item(req, bgr_pkg::COORD_W'(c), bgr_pkg::COORD_W'(r), s)) taken++;
	endtask

	// Write a neighbor that was never written, and now and then overwrite one.
	task automatic fill_point(input int unsigned x, input int unsigned y);
		if (!sb.filled[y * bgr_pkg::SRC_W_MAX + x] || $urandom_range(0, 7) == 0)
			send_item(bgr_pkg::REQ_WRITE, x, y, rand_sample());
	endtask

	task automatic ask_pixel(input int unsigned c, input int unsigned r);
		int unsigned      x0, x1, y0, y1;
		longint unsigned  fx, fy;
		if (c < sb.dst_w() && r < sb.dst_h()) begin
			sb.corners(c, r, x0, x1, y0, y1, fx, fy);
			fill_point(x0, y0);
			fill_point(x1, y0);
			fill_point(x0, y1);
			fill_point(x1, y1);
		end
		send_item(bgr_pkg::REQ_QUERY, c, r, rand_sample());
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
	endtask

	// Let the last write retire as well before touching the registers.
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bgr_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[bgr_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_register(idx, data[bgr_pkg::CFG_DATA_W-1:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input int unsigned sw, sh, tw, th);
		settle();
		write_reg(bgr_pkg::CFG_SRC_WIDTH, sw);
		write_reg(bgr_pkg::CFG_SRC_HEIGHT, sh);
		write_reg(bgr_pkg::CFG_DST_WIDTH, tw);
		write_reg(bgr_pkg::CFG_DST_HEIGHT, th);
	endtask

	task automatic run_phase(input int count, input bit pause_midway);
		int goal;
		int sel;
		bit paused;
		goal = taken + count;
		paused = 1'b0;
		while (taken < goal) begin
			sel = $urandom_range(0, 99);
			if (pause_midway && !paused && taken >= goal - count / 2) begin
				wait_results();
				paused = 1'b1;
			end
			if (sel < 65)
				ask_pixel($urandom_range(0, sb.dst_w() - 1), $urandom_range(0, sb.dst_h() - 1));
			else if (sel < 78)
				send_item(bgr_pkg::REQ_WRITE, $urandom_range(0, sb.src_w() - 1),
					$urandom_range(0, sb.src_h() - 1), rand_sample());
			else if (sel < 84 && sb.dst_w() < bgr_pkg::DST_MAX)
				ask_pixel($urandom_range(sb.dst_w(), 4095), $urandom_range(0, 4095));
			else if (sel < 90 && sb.dst_h() < bgr_pkg::DST_MAX)
				ask_pixel($urandom_range(0, 4095), $urandom_range(sb.dst_h(), 4095));
			else if (sel < 95)
				send_item(bgr_pkg::REQ_WRITE, $urandom_range(0, 4095),
					$urandom_range(0, 4095), bgr_pkg::SMP_W'($urandom));
			else
				ask_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
		end
	endtask

	initial begin
		int unsigned sw, sh, tw, th;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: corners of the reset-size grid, ignored writes, range errors.
		send_item(bgr_pkg::REQ_WRITE, 0, 0, -16'sd32768);
		send_item(bgr_pkg::REQ_WRITE, 511, 255, 16'sd32767);
		ask_pixel(0, 0);
		ask_pixel(511, 255);
		send_item(bgr_pkg::REQ_WRITE, 512, 0, 16'sd1);
		send_item(bgr_pkg::REQ_WRITE, 0, 256, -16'sd1);
		send_item(bgr_pkg::REQ_WRITE, 4095, 4095, -16'sd1);
		ask_pixel(512, 0);
		ask_pixel(0, 256);
		ask_pixel(4095, 4095);
		ask_pixel(0, 0);

		// Directed: fractional positions and out-of-range queries on a tiny upscaled grid.
		apply_config(3, 2, 5, 4);
		ask_pixel(1, 1);
		ask_pixel(3, 2);
		ask_pixel(4, 3);
		ask_pixel(2, 0);
		ask_pixel(5, 0);
		ask_pixel(0, 4);

		apply_config(2, 2, 2, 2);
		run_phase(150, 1'b0);
		apply_config(512, 256, 4096, 4096);
		run_phase(150, 1'b0);
		// below the floor: every size becomes 2
		apply_config(0, 1, 0, 1);
		run_phase(100, 1'b0);
		// upper bits are dropped per register; the target sizes then clamp to the maximum
		apply_config(13'h1003, 13'h1E05, 8191, 5000);
		run_phase(150, 1'b1);
		apply_config(1023, 511, 3, 2);
		run_phase(150, 1'b0);
		apply_config(7, 5, 40, 33);
		run_phase(150, 1'b0);
		apply_config(300, 200, 17, 9);
		run_phase(150, 1'b0);
		repeat (3) begin
			sw = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 20);
			sh = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 12);
			tw = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(2, 70);
			th = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(2, 70);
			apply_config(sw, sh, tw, th);
			run_phase(150, 1'b0);
		end

		apply_config(9, 6, 23, 14);
		quiet = 1'b1;
		run_phase(150, 1'b0);

		settle();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
src/bgr_pkg.sv
src/bgr_ram.sv
src/bgr_div.sv
src/bgr_mac.sv
src/bilinear_grid_resampler.sv
dv/bilinear_grid_resampler_tb.sv
